FILE: rtl/cbf_pkg.sv
// cbf_pkg: shared constants and state types of the cubic bezier flattener
// depends on nothing; imported by every rtl module of the block

package cbf_pkg;

    localparam int unsigned COORD_WIDTH_DEF  = 16;
    localparam int unsigned MAX_SEGMENTS_DEF = 63;
    localparam int unsigned QUEUE_DEPTH_DEF  = 2;

    // segment count field and anything bounded by it
    localparam int unsigned SEG_W     = 6;
    // t is unsigned q1.16
    localparam int unsigned T_FRAC    = 16;
    localparam int unsigned T_W       = T_FRAC + 1;
    // 2^16 / n takes one quotient bit per dividend bit
    localparam int unsigned DIV_STEPS = T_W;
    // blend sum is q.52, rounded back to q.4
    localparam int unsigned SUM_FRAC  = 3 * T_FRAC;
    // slice of the running horner value fed to the multiplier each cycle
    localparam int unsigned CHUNK_W   = 32;
    localparam int unsigned LAST_ROUND = 2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_STEP,
        B_INIT,
        B_EVAL,
        B_OUT
    } back_state_t;

endpackage

FILE: rtl/cbf_front.sv
// cbf_front: accepts segments, forms polynomial coefficients and the t step
// depends on cbf_pkg

module cbf_front import cbf_pkg::*; #(
    parameter int unsigned COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    localparam int unsigned DW          = COORD_WIDTH + 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_WIDTH-1:0]  s_x_ctrl0,
    input  logic signed [COORD_WIDTH-1:0]  s_y_ctrl0,
    input  logic signed [COORD_WIDTH-1:0]  s_x_ctrl1,
    input  logic signed [COORD_WIDTH-1:0]  s_y_ctrl1,
    input  logic signed [COORD_WIDTH-1:0]  s_x_ctrl2,
    input  logic signed [COORD_WIDTH-1:0]  s_y_ctrl2,
    input  logic signed [COORD_WIDTH-1:0]  s_x_ctrl3,
    input  logic signed [COORD_WIDTH-1:0]  s_y_ctrl3,
    input  logic        [SEG_W-1:0]        s_segment_count,
    input  logic                           s_path_start,
    output logic                           push_valid,
    input  logic                           push_ready,
    output logic [3:0][DW-1:0]             coef_x,
    output logic [3:0][DW-1:0]             coef_y,
    output logic [SEG_W-1:0]               seg_n,
    output logic                           seg_start,
    output logic [T_W-1:0]                 t_inc,
    output logic [SEG_W-1:0]               r_inc
);

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    front_state_t           state_reg, state_next;
    logic [3:0][DW-1:0]     coef_x_reg, coef_y_reg;
    logic [SEG_W-1:0]       n_reg;
    logic                   start_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [T_W-1:0]         quo_reg;
    logic [SEG_W-1:0]       rem_reg;
    logic [SEG_W-1:0]       n_clamped;
    logic [SEG_W:0]         rem_shift;
    logic                   rem_ge;
    logic                   accept;

    // power basis of the bernstein form: p0, 3(p1-p0), 3(p0-2p1+p2), p3-p0+3(p1-p2)
    function automatic logic [3:0][DW-1:0] bez_coef(
        input logic signed [DW-1:0] p0,
        input logic signed [DW-1:0] p1,
        input logic signed [DW-1:0] p2,
        input logic signed [DW-1:0] p3
    );
        logic signed [DW-1:0] e1, e2, e3;
        logic [3:0][DW-1:0]   r;
        e1 = p1 - p0;
        e2 = p0 - (p1 <<< 1) + p2;
        e3 = (p1 - p2) + ((p1 - p2) <<< 1);
        r[0] = p0;
        r[1] = e1 + (e1 <<< 1);
        r[2] = e2 + (e2 <<< 1);
        r[3] = p3 - p0 + e3;
        return r;
    endfunction

    assign accept    = s_valid && s_ready;
    assign n_clamped = (s_segment_count > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS)
                                                               : s_segment_count;

    // dividend 2^16 enters msb first: a one, then zeros
    assign rem_shift = {rem_reg, (cnt_reg == '0)};
    assign rem_ge    = (rem_shift >= {1'b0, n_reg});

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_DIV;
                end
            end
            F_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == F_IDLE);
        push_valid = (state_reg == F_PUSH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            coef_x_reg <= bez_coef(DW'(s_x_ctrl0), DW'(s_x_ctrl1),
                                   DW'(s_x_ctrl2), DW'(s_x_ctrl3));
            coef_y_reg <= bez_coef(DW'(s_y_ctrl0), DW'(s_y_ctrl1),
                                   DW'(s_y_ctrl2), DW'(s_y_ctrl3));
            n_reg      <= n_clamped;
            start_reg  <= s_path_start;
            cnt_reg    <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
        end else if (state_reg == F_DIV) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            quo_reg <= {quo_reg[T_W-2:0], rem_ge};
            rem_reg <= rem_ge ? SEG_W'(rem_shift - {1'b0, n_reg}) : SEG_W'(rem_shift);
        end
    end

    assign coef_x    = coef_x_reg;
    assign coef_y    = coef_y_reg;
    assign seg_n     = n_reg;
    assign seg_start = start_reg;
    assign t_inc     = quo_reg;
    assign r_inc     = rem_reg;

endmodule

FILE: rtl/cbf_queue.sv
// cbf_queue: small register fifo between the front and back halves
// depends on cbf_pkg

module cbf_queue import cbf_pkg::*; #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= ptr_inc(wptr_reg);
            end
            if (pop) begin
                rptr_reg <= ptr_inc(rptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/cbf_back.sv
// cbf_back: steps t across a segment and evaluates each point by horner
// depends on cbf_pkg; takes work from cbf_queue

module cbf_back import cbf_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int unsigned DW         = COORD_WIDTH + 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic [3:0][DW-1:0]            coef_x,
    input  logic [3:0][DW-1:0]            coef_y,
    input  logic [SEG_W-1:0]              seg_n,
    input  logic                          seg_start,
    input  logic [T_W-1:0]                t_inc,
    input  logic [SEG_W-1:0]              r_inc,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_point_x,
    output logic signed [COORD_WIDTH-1:0] m_point_y,
    output logic                          m_last_point
);

    // the exact blend fits this width; horner runs modulo 2^ACC_W
    localparam int unsigned ACC_W  = COORD_WIDTH + SUM_FRAC + 1;
    localparam int unsigned NCH    = (ACC_W + CHUNK_W - 1) / CHUNK_W;
    localparam int unsigned SRC_W  = NCH * CHUNK_W;
    localparam int unsigned PROD_W = CHUNK_W + T_W;
    localparam int unsigned KCNT_W = $clog2(NCH + 1);

    back_state_t        state_reg, state_next;
    logic [3:0][DW-1:0] cx_reg, cy_reg;
    logic [SEG_W-1:0]   n_reg, i_reg, rinc_reg, r_reg;
    logic [T_W-1:0]     tinc_reg, t_reg;
    logic [1:0]         round_reg;
    logic [KCNT_W-1:0]  k_reg;
    logic [SRC_W-1:0]   src_x_reg, src_y_reg;
    logic [PROD_W-1:0]  prod_x_reg, prod_y_reg;
    logic [ACC_W-1:0]   acc_x_reg, acc_y_reg;
    logic [ACC_W-1:0]   sum_x, sum_y, rnd_x, rnd_y;
    logic [ACC_W-1:0]   add_x, add_y;
    logic               m_valid_reg, last_reg;
    logic [COORD_WIDTH-1:0] px_reg, py_reg;
    logic [SEG_W:0]     r_sum;
    logic [SEG_W-1:0]   r_step;
    logic [T_W-1:0]     t_step;
    logic               o_free, out_load, round_end, is_last;
    int                 shamt;

    function automatic logic [ACC_W-1:0] sext_acc(input logic [DW-1:0] v);
        return ACC_W'($signed(v));
    endfunction

    function automatic logic [SRC_W-1:0] pad_src(input logic [ACC_W-1:0] v);
        return SRC_W'(v);
    endfunction

    // value added at the start of a horner round: next coefficient times 2^16 powers
    function automatic logic [ACC_W-1:0] addend(input logic [3:0][DW-1:0] c,
                                                input logic [1:0] rnd);
        logic [ACC_W-1:0] r;
        case (rnd)
            2'd0:    r = sext_acc(c[2]) << T_FRAC;
            2'd1:    r = sext_acc(c[1]) << (2 * T_FRAC);
            default: r = sext_acc(c[0]) << (3 * T_FRAC);
        endcase
        return r;
    endfunction

    assign o_free    = !m_valid_reg || m_ready;
    assign round_end = (k_reg == KCNT_W'(NCH));
    assign is_last   = (i_reg == n_reg);

    // t(i) = floor(i * 2^16 / n) kept as quotient and remainder
    assign r_sum  = {1'b0, r_reg} + {1'b0, rinc_reg};
    assign r_step = (r_sum >= {1'b0, n_reg}) ? SEG_W'(r_sum - {1'b0, n_reg}) : SEG_W'(r_sum);
    assign t_step = t_reg + tinc_reg + T_W'(r_sum >= {1'b0, n_reg});

    always_comb begin
        shamt = (int'(k_reg) - 1) * CHUNK_W;
        add_x = ACC_W'(prod_x_reg) << shamt;
        add_y = ACC_W'(prod_y_reg) << shamt;
        sum_x = acc_x_reg + add_x;
        sum_y = acc_y_reg + add_y;
        rnd_x = acc_x_reg + (ACC_W'(1) << (SUM_FRAC - 1));
        rnd_y = acc_y_reg + (ACC_W'(1) << (SUM_FRAC - 1));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    if (seg_start) begin
                        state_next = B_INIT;
                    end else if (seg_n != '0) begin
                        state_next = B_STEP;
                    end
                end
            end
            B_STEP: state_next = B_INIT;
            B_INIT: state_next = B_EVAL;
            B_EVAL: begin
                if (round_end && round_reg == 2'(LAST_ROUND)) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (o_free) begin
                    state_next = is_last ? B_IDLE : B_STEP;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = (state_reg == B_IDLE) && !q_empty;
        out_load = (state_reg == B_OUT) && o_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    cx_reg   <= coef_x;
                    cy_reg   <= coef_y;
                    n_reg    <= seg_n;
                    tinc_reg <= t_inc;
                    rinc_reg <= r_inc;
                    t_reg    <= '0;
                    r_reg    <= '0;
                    i_reg    <= '0;
                end
            end
            B_STEP: begin
                i_reg <= i_reg + SEG_W'(1);
                t_reg <= t_step;
                r_reg <= r_step;
            end
            B_INIT: begin
                src_x_reg <= pad_src(sext_acc(cx_reg[3]));
                src_y_reg <= pad_src(sext_acc(cy_reg[3]));
                acc_x_reg <= addend(cx_reg, 2'd0);
                acc_y_reg <= addend(cy_reg, 2'd0);
                round_reg <= '0;
                k_reg     <= '0;
            end
            B_EVAL: begin
                // one chunk multiplied per cycle, added in the cycle after
                if (!round_end) begin
                    prod_x_reg <= PROD_W'(src_x_reg[CHUNK_W-1:0]) * PROD_W'(t_reg);
                    prod_y_reg <= PROD_W'(src_y_reg[CHUNK_W-1:0]) * PROD_W'(t_reg);
                    src_x_reg  <= src_x_reg >> CHUNK_W;
                    src_y_reg  <= src_y_reg >> CHUNK_W;
                end
                if (round_end) begin
                    k_reg <= '0;
                    if (round_reg == 2'(LAST_ROUND)) begin
                        acc_x_reg <= sum_x;
                        acc_y_reg <= sum_y;
                    end else begin
                        src_x_reg <= pad_src(sum_x);
                        src_y_reg <= pad_src(sum_y);
                        acc_x_reg <= addend(cx_reg, round_reg + 2'd1);
                        acc_y_reg <= addend(cy_reg, round_reg + 2'd1);
                        round_reg <= round_reg + 2'd1;
                    end
                end else begin
                    k_reg <= k_reg + KCNT_W'(1);
                    if (k_reg != '0) begin
                        acc_x_reg <= sum_x;
                        acc_y_reg <= sum_y;
                    end
                end
            end
            default: ;
        endcase
        if (out_load) begin
            px_reg   <= rnd_x[SUM_FRAC +: COORD_WIDTH];
            py_reg   <= rnd_y[SUM_FRAC +: COORD_WIDTH];
            last_reg <= is_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_point_x    = $signed(px_reg);
    assign m_point_y    = $signed(py_reg);
    assign m_last_point = last_reg;

endmodule

FILE: rtl/cubic_bezier_flattener.sv
// cubic_bezier_flattener: top level, front half, queue and back half
// depends on cbf_pkg, cbf_front, cbf_queue, cbf_back
//
// Input channel s_*: one cubic segment per word, four control points in
// signed q11.4, a segment count n (clamped to MAX_SEGMENTS) and a path start
// flag. Result channel m_*: curve points in q11.4, the t=0 point first when
// path_start is set, then t=i/n for i=1..n; m_last_point marks the final
// point of each segment. A segment with n=0 and no path start yields nothing.
// The front half takes a word, forms power-basis coefficients and divides
// 2^16 by n one quotient bit per cycle, and it takes the next word as soon
// as the previous one sits in the 2-entry queue. The back half evaluates
// each point by three horner rounds on a 32 x 17 multiplier per axis; when
// path_start is clear it first steps t to i=1 before the first point.
// The output register holds a point until m_ready; the back half then waits
// and the queue and front half fill up before s_ready drops.
// Reset (aresetn low, synchronous) empties the queue and the output register.

module cubic_bezier_flattener import cbf_pkg::*; #(
    parameter int unsigned COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_x_ctrl0,
    input  logic signed [COORD_WIDTH-1:0] s_y_ctrl0,
    input  logic signed [COORD_WIDTH-1:0] s_x_ctrl1,
    input  logic signed [COORD_WIDTH-1:0] s_y_ctrl1,
    input  logic signed [COORD_WIDTH-1:0] s_x_ctrl2,
    input  logic signed [COORD_WIDTH-1:0] s_y_ctrl2,
    input  logic signed [COORD_WIDTH-1:0] s_x_ctrl3,
    input  logic signed [COORD_WIDTH-1:0] s_y_ctrl3,
    input  logic        [SEG_W-1:0]       s_segment_count,
    input  logic                          s_path_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_point_x,
    output logic signed [COORD_WIDTH-1:0] m_point_y,
    output logic                          m_last_point
);

    localparam int unsigned DW = COORD_WIDTH + 4;
    localparam int unsigned QW = 8 * DW + 2 * SEG_W + 1 + T_W;

    logic               push_valid, push_ready;
    logic [3:0][DW-1:0] f_coef_x, f_coef_y, b_coef_x, b_coef_y;
    logic [SEG_W-1:0]   f_seg_n, b_seg_n, f_r_inc, b_r_inc;
    logic               f_start, b_start;
    logic [T_W-1:0]     f_t_inc, b_t_inc;
    logic [QW-1:0]      push_data, pop_data;
    logic               q_full, q_empty, q_pop;

    cbf_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_x_ctrl0       (s_x_ctrl0),
        .s_y_ctrl0       (s_y_ctrl0),
        .s_x_ctrl1       (s_x_ctrl1),
        .s_y_ctrl1       (s_y_ctrl1),
        .s_x_ctrl2       (s_x_ctrl2),
        .s_y_ctrl2       (s_y_ctrl2),
        .s_x_ctrl3       (s_x_ctrl3),
        .s_y_ctrl3       (s_y_ctrl3),
        .s_segment_count (s_segment_count),
        .s_path_start    (s_path_start),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .coef_x          (f_coef_x),
        .coef_y          (f_coef_y),
        .seg_n           (f_seg_n),
        .seg_start       (f_start),
        .t_inc           (f_t_inc),
        .r_inc           (f_r_inc)
    );

    assign push_ready = !q_full;
    assign push_data  = {f_coef_x, f_coef_y, f_seg_n, f_start, f_t_inc, f_r_inc};

    cbf_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH_DEF)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid && push_ready),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    assign {b_coef_x, b_coef_y, b_seg_n, b_start, b_t_inc, b_r_inc} = pop_data;

    cbf_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .coef_x       (b_coef_x),
        .coef_y       (b_coef_y),
        .seg_n        (b_seg_n),
        .seg_start    (b_start),
        .t_inc        (b_t_inc),
        .r_inc        (b_r_inc),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_last_point (m_last_point)
    );

`ifndef SYNTHESIS
    // the back half only pops a word that is there
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // the front half takes no word while a finished one waits for the queue
    assert property (@(posedge aclk) disable iff (!aresetn) push_valid |-> !s_ready)
        else $error("front accepted a word while pushing");

    // a push into a full queue would drop a segment
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push_valid && q_full) |=> push_valid)
        else $error("front released a word the queue did not take");
`endif

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for cubic_bezier_flattener, directed table then random segments
// depends on cbf_pkg and the rtl of the block; points are checked against a local predictor or typed expectations
`timescale 1ns / 1ps

module tb import cbf_pkg::*; ();

    localparam int CW = COORD_WIDTH_DEF;
    localparam int MAXSEG = MAX_SEGMENTS_DEF;
    localparam int N_RANDOM = 364;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic signed [CW-1:0] ctrl [8];
        logic [SEG_W-1:0]     segs;
        logic                 start;
    } segment_t;

    typedef struct {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic                 last;
    } point_t;

    typedef struct {
        segment_t seg;
        bit       fixed_exp;
        point_t   fexp;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [CW-1:0] s_ctrl [8];
    logic [SEG_W-1:0] s_segment_count = '0;
    logic s_path_start = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [CW-1:0] m_point_x, m_point_y;
    logic m_last_point;

    point_t expected_points[$];
    int  errors = 0;
    int  points_seen = 0;
    longint cycles = 0;
    bit  no_idle = 0;

    initial for (int k = 0; k < 8; k++) s_ctrl[k] = '0;

    always #2 aclk = ~aclk;

    cubic_bezier_flattener uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_x_ctrl0(s_ctrl[0]), .s_y_ctrl0(s_ctrl[1]),
        .s_x_ctrl1(s_ctrl[2]), .s_y_ctrl1(s_ctrl[3]),
        .s_x_ctrl2(s_ctrl[4]), .s_y_ctrl2(s_ctrl[5]),
        .s_x_ctrl3(s_ctrl[6]), .s_y_ctrl3(s_ctrl[7]),
        .s_segment_count(s_segment_count), .s_path_start(s_path_start),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_x(m_point_x), .m_point_y(m_point_y), .m_last_point(m_last_point)
    );

    // exact bernstein blend, q11.52 sum rounded half up to q11.4
    function automatic logic signed [CW-1:0] bezier_coord(logic signed [CW-1:0] c0,
            logic signed [CW-1:0] c1, logic signed [CW-1:0] c2, logic signed [CW-1:0] c3,
            logic [T_W-1:0] t);
        logic signed [127:0] u, tt, acc;
        u = 128'sd65536 - $signed({111'd0, t});
        tt = $signed({111'd0, t});
        acc = c0 * u * u * u + 3 * c1 * u * u * tt + 3 * c2 * u * tt * tt
            + c3 * tt * tt * tt + (128'sd1 <<< 47);
        acc = acc >>> 48;
        return acc[CW-1:0];
    endfunction

    task automatic predict_points(segment_t sg);
        int n;
        point_t p;
        logic [T_W-1:0] t;
        n = (sg.segs > MAXSEG) ? MAXSEG : sg.segs;
        for (int i = (sg.start ? 0 : 1); i <= n; i++) begin
            t = (i == 0) ? '0 : T_W'((longint'(i) * 65536) / n);
            p.px = bezier_coord(sg.ctrl[0], sg.ctrl[2], sg.ctrl[4], sg.ctrl[6], t);
            p.py = bezier_coord(sg.ctrl[1], sg.ctrl[3], sg.ctrl[5], sg.ctrl[7], t);
            p.last = (i == n);
            expected_points.insert(expected_points.size(), p);
        end
    endtask

    // valid drops only for idle cycles, so a word can follow right after acceptance
    task automatic drive_segment(segment_t sg);
        while (!no_idle && $urandom_range(99) < 23) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_ctrl <= sg.ctrl;
        s_segment_count <= sg.segs;
        s_path_start <= sg.start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_segment(segment_t sg);
        predict_points(sg);
        drive_segment(sg);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return CW'(int'($urandom_range(200)) - 100);
            default: return CW'($urandom);
        endcase
    endfunction

    // result side: random stall, check against oldest expected point
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                points_seen <= points_seen + 1;
                if (expected_points.size() == 0) begin
                    $error("unexpected point x=%0d y=%0d", m_point_x, m_point_y);
                    errors = errors + 1;
                end else begin
                    point_t e;
                    e = expected_points.pop_front();
                    if (m_point_x !== e.px) begin
                        $error("point_x expected %0d got %0d", e.px, m_point_x);
                        errors = errors + 1;
                    end
                    if (m_point_y !== e.py) begin
                        $error("point_y expected %0d got %0d", e.py, m_point_y);
                        errors = errors + 1;
                    end
                    if (m_last_point !== e.last) begin
                        $error("last_point expected %0d got %0d", e.last, m_last_point);
                        errors = errors + 1;
                    end
                end
            end
            m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 23);
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    row_t table_rows[$];

    function automatic row_t mk_row(logic signed [CW-1:0] v, logic [SEG_W-1:0] n, logic st);
        row_t r;
        for (int k = 0; k < 8; k++) r.seg.ctrl[k] = v;
        r.seg.segs = n;
        r.seg.start = st;
        r.fixed_exp = 0;
        return r;
    endfunction

    initial begin
        row_t r;
        segment_t sg;
        // flat curves: every point equals the control value, easy to read off
        r = mk_row(16'sh7fff, 6'd0, 1'b1); r.fixed_exp = 1;
        r.fexp = '{16'sh7fff, 16'sh7fff, 1'b1};
        table_rows.insert(table_rows.size(), r);
        r = mk_row(16'sh8000, 6'd0, 1'b1); r.fixed_exp = 1;
        r.fexp = '{16'sh8000, 16'sh8000, 1'b1};
        table_rows.insert(table_rows.size(), r);
        // zero segments, no start: nothing
        r = mk_row(16'sh0000, 6'd0, 1'b0); table_rows.insert(table_rows.size(), r);
        r = mk_row(16'sh1234, 6'd1, 1'b0); r.fixed_exp = 1;
        r.fexp = '{16'sh1234, 16'sh1234, 1'b1};
        table_rows.insert(table_rows.size(), r);
        r = mk_row(-16'sd5, 6'd1, 1'b1); table_rows.insert(table_rows.size(), r);
        r = mk_row(16'sh0000, 6'd63, 1'b1); table_rows.insert(table_rows.size(), r);
        // extreme hulls with full range swings
        for (int k = 0; k < 8; k++) begin
            r = mk_row(16'sh0000, SEG_W'(k * 9 + 1), k[0]);
            for (int j = 0; j < 8; j++)
                r.seg.ctrl[j] = ((j + k) % 2) ? 16'sh7fff : 16'sh8000;
            table_rows.insert(table_rows.size(), r);
        end
        r = mk_row(16'sh0000, 6'd63, 1'b0);
        r.seg.ctrl = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                       16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
        table_rows.insert(table_rows.size(), r);
        r = mk_row(16'sh0000, 6'd3, 1'b1);
        r.seg.ctrl = '{16'sh0001, 16'shffff, 16'sh0010, 16'shfff0,
                       16'sh0100, 16'shff00, 16'sh1000, 16'shf000};
        table_rows.insert(table_rows.size(), r);

        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (table_rows[i]) begin
            if (table_rows[i].fixed_exp) begin
                // typed expectation replaces the predictor for this row
                expected_points.insert(expected_points.size(), table_rows[i].fexp);
                drive_segment(table_rows[i].seg);
            end else begin
                send_segment(table_rows[i].seg);
            end
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            no_idle = (i >= 150 && i < 200);
            for (int k = 0; k < 8; k++) sg.ctrl[k] = rand_coord();
            // mostly short segments to keep the run brief
            sg.segs = ($urandom_range(9) == 0) ? SEG_W'($urandom) : SEG_W'($urandom_range(8));
            sg.start = 1'($urandom_range(1));
            send_segment(sg);
        end
        s_valid <= 0;
        no_idle = 0;

        while (expected_points.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("covered %0d segments, %0d points checked", table_rows.size() + N_RANDOM,
                 points_seen);
        if (errors == 0 && expected_points.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
